>>> hdl/jos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JVM operand stack unit package
// Opcode codes, constant words, status and state types, and the opcode decode.
// ----------------------------------------------------------------------------
package jos_pkg;

    // JVM opcode bytes
    localparam logic [7:0] OP_NOP         = 8'h00;
    localparam logic [7:0] OP_ACONST_NULL = 8'h01;
    localparam logic [7:0] OP_ICONST_M1   = 8'h02;
    localparam logic [7:0] OP_ICONST_5    = 8'h08;
    localparam logic [7:0] OP_LCONST_0    = 8'h09;
    localparam logic [7:0] OP_LCONST_1    = 8'h0A;
    localparam logic [7:0] OP_FCONST_0    = 8'h0B;
    localparam logic [7:0] OP_FCONST_1    = 8'h0C;
    localparam logic [7:0] OP_FCONST_2    = 8'h0D;
    localparam logic [7:0] OP_DCONST_0    = 8'h0E;
    localparam logic [7:0] OP_DCONST_1    = 8'h0F;
    localparam logic [7:0] OP_BIPUSH      = 8'h10;
    localparam logic [7:0] OP_SIPUSH      = 8'h11;
    localparam logic [7:0] OP_POP         = 8'h57;
    localparam logic [7:0] OP_POP2        = 8'h58;
    localparam logic [7:0] OP_DUP         = 8'h59;
    localparam logic [7:0] OP_DUP_X1      = 8'h5A;
    localparam logic [7:0] OP_DUP_X2      = 8'h5B;
    localparam logic [7:0] OP_DUP2        = 8'h5C;
    localparam logic [7:0] OP_DUP2_X1     = 8'h5D;
    localparam logic [7:0] OP_DUP2_X2     = 8'h5E;
    localparam logic [7:0] OP_SWAP        = 8'h5F;

    // IEEE-754 bit patterns
    localparam logic [31:0] FLT_ONE    = 32'h3F80_0000;
    localparam logic [31:0] FLT_TWO    = 32'h4000_0000;
    localparam logic [31:0] DBL_ONE_HI = 32'h3FF0_0000;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2,
        STAT_UNSUP = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_FETCH,
        S_DONE
    } state_t;

    // Decoded opcode. src holds, two bits per pushed word (word 0 lowest),
    // which popped slot feeds it: 0 is the old top, 3 the fourth from top.
    typedef struct packed {
        logic        supported;
        logic        shuffle;
        logic [2:0]  npop;
        logic [2:0]  npush;
        logic [15:0] src;
        logic [31:0] w0;
        logic [31:0] w1;
    } dec_t;

    function automatic dec_t decode(input logic [7:0] cmd, input logic [15:0] imm);
        dec_t d;
        d           = '0;
        d.supported = 1'b1;
        case (cmd) inside
            OP_NOP:
            begin
                d.npush = 3'd0;
            end
            OP_ACONST_NULL, OP_FCONST_0:
            begin
                d.npush = 3'd1;
            end
            [OP_ICONST_M1:OP_ICONST_5]:
            begin
                d.npush = 3'd1;
                d.w0    = 32'(cmd) - 32'd3;
            end
            OP_LCONST_0, OP_LCONST_1:
            begin
                d.npush = 3'd2;
                d.w1    = 32'(cmd) - 32'd9;
            end
            OP_FCONST_1:
            begin
                d.npush = 3'd1;
                d.w0    = FLT_ONE;
            end
            OP_FCONST_2:
            begin
                d.npush = 3'd1;
                d.w0    = FLT_TWO;
            end
            OP_DCONST_0:
            begin
                d.npush = 3'd2;
            end
            OP_DCONST_1:
            begin
                d.npush = 3'd2;
                d.w0    = DBL_ONE_HI;
            end
            OP_BIPUSH:
            begin
                d.npush = 3'd1;
                d.w0    = {{24{imm[7]}}, imm[7:0]};
            end
            OP_SIPUSH:
            begin
                d.npush = 3'd1;
                d.w0    = {{16{imm[15]}}, imm};
            end
            OP_POP:
            begin
                d.npop = 3'd1;
            end
            OP_POP2:
            begin
                d.npop = 3'd2;
            end
            OP_DUP:
            begin
                d.npop    = 3'd1;
                d.npush   = 3'd2;
                d.shuffle = 1'b1;
                d.src     = {4'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
            end
            OP_DUP_X1:
            begin
                d.npop    = 3'd2;
                d.npush   = 3'd3;
                d.shuffle = 1'b1;
                d.src     = {4'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0};
            end
            OP_DUP_X2:
            begin
                d.npop    = 3'd3;
                d.npush   = 3'd4;
                d.shuffle = 1'b1;
                d.src     = {4'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0};
            end
            OP_DUP2:
            begin
                d.npop    = 3'd2;
                d.npush   = 3'd4;
                d.shuffle = 1'b1;
                d.src     = {4'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1};
            end
            OP_DUP2_X1:
            begin
                d.npop    = 3'd3;
                d.npush   = 3'd5;
                d.shuffle = 1'b1;
                d.src     = {4'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1};
            end
            OP_DUP2_X2:
            begin
                d.npop    = 3'd4;
                d.npush   = 3'd6;
                d.shuffle = 1'b1;
                d.src     = {4'd0, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1};
            end
            OP_SWAP:
            begin
                d.npop    = 3'd2;
                d.npush   = 3'd2;
                d.shuffle = 1'b1;
                d.src     = {4'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0};
            end
            default:
            begin
                d.supported = 1'b0;
            end
        endcase
        return d;
    endfunction

endpackage

>>> hdl/jvm_operand_stack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JVM operand stack unit
// Executes one JVM stack opcode per input transfer against a slot stack held
// in a synchronous RAM, and returns the new top two slots, depth and status.
// ----------------------------------------------------------------------------
// One opcode is taken per transfer and one result comes back for it. The
// stack lives in a single RAM with one write and one read port and a
// registered read. An opcode passes through an accept step, one RAM read per
// popped slot of a dup or swap, one RAM write per pushed slot, two reads of
// the new top and second slot and a load of the result register. The result
// register lets the next opcode be accepted while the previous result waits.
// There is no clearing pass after reset; only occupied slots are ever read.
module jvm_operand_stack_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] cmd, [23:8] immediate
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata   // [31:0] top_word, [63:32] second_word,
                                       // [70:64] depth, [72:71] status, rest 0
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int CW  = SPW + 3;

    jos_pkg::state_t  state_reg, state_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    logic [SPW-1:0]   base_reg, base_next;
    jos_pkg::dec_t    dec_reg, dec_next;
    jos_pkg::status_t status_reg, status_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [1:0]       rd_tag_reg, rd_tag_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_top_reg, out_sec_reg;
    logic [6:0]       out_depth_reg;
    jos_pkg::status_t out_status_reg;
    logic             out_load;

    logic [31:0]      stack_mem [STACK_DEPTH];
    logic [31:0]      rd_data_reg;
    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [31:0]      wr_data;

    logic [31:0]      v_reg [4];
    logic [31:0]      v_fwd [4];

    jos_pkg::dec_t    in_dec;
    jos_pkg::status_t in_status;
    logic [CW-1:0]    sp_ext, npop_ext, npush_ext;
    logic [1:0]       src;

    assign s_axis_tready = (state_reg == jos_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_status_reg, out_depth_reg, out_sec_reg, out_top_reg};

    // Decode and check the incoming opcode
    always_comb
    begin
        in_dec    = jos_pkg::decode(s_axis_tdata[7:0], s_axis_tdata[23:8]);
        sp_ext    = CW'(sp_reg);
        npop_ext  = CW'(in_dec.npop);
        npush_ext = CW'(in_dec.npush);
        if (!in_dec.supported)
            in_status = jos_pkg::STAT_UNSUP;
        else if (sp_ext < npop_ext)
            in_status = jos_pkg::STAT_UNDER;
        else if (sp_ext + npush_ext > CW'(STACK_DEPTH) + npop_ext)
            in_status = jos_pkg::STAT_OVER;
        else
            in_status = jos_pkg::STAT_OK;
    end

    // Forward the word that is just coming out of the RAM
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            v_fwd[k] = (rd_valid_reg && rd_tag_reg == 2'(k)) ? rd_data_reg : v_reg[k];
        end
    end

    assign src = dec_reg.src[{cnt_reg, 1'b0} +: 2];

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        base_next      = base_reg;
        dec_next       = dec_reg;
        status_next    = status_reg;
        cnt_next       = cnt_reg;
        rd_valid_next  = 1'b0;
        rd_tag_next    = 2'd0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;

        case (state_reg)
            jos_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    dec_next    = in_dec;
                    status_next = in_status;
                    base_next   = SPW'(sp_ext - npop_ext);
                    cnt_next    = 3'd0;
                    if (in_status == jos_pkg::STAT_OK)
                    begin
                        sp_next = SPW'(sp_ext - npop_ext + npush_ext);
                        if (in_dec.shuffle)
                            state_next = jos_pkg::S_READ;
                        else if (in_dec.npush != 3'd0)
                            state_next = jos_pkg::S_WRITE;
                        else
                            state_next = jos_pkg::S_FETCH;
                    end
                    else
                    begin
                        state_next = jos_pkg::S_FETCH;
                    end
                end
            end
            jos_pkg::S_READ:
            begin
                // Read popped slots from the top down
                rd_en         = 1'b1;
                rd_addr       = AW'(base_reg + SPW'(dec_reg.npop) - SPW'(1) - SPW'(cnt_reg));
                rd_valid_next = 1'b1;
                rd_tag_next   = cnt_reg[1:0];
                if (cnt_reg == dec_reg.npop - 3'd1)
                begin
                    cnt_next   = 3'd0;
                    state_next = jos_pkg::S_WRITE;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            jos_pkg::S_WRITE:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(base_reg + SPW'(cnt_reg));
                if (dec_reg.shuffle)
                    wr_data = v_fwd[src];
                else if (cnt_reg == 3'd0)
                    wr_data = dec_reg.w0;
                else
                    wr_data = dec_reg.w1;
                if (cnt_reg == dec_reg.npush - 3'd1)
                begin
                    cnt_next   = 3'd0;
                    state_next = jos_pkg::S_FETCH;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            jos_pkg::S_FETCH:
            begin
                // Read the new top, then the slot below it, where present
                rd_en         = sp_reg > SPW'(cnt_reg);
                rd_addr       = AW'(sp_reg - SPW'(1) - SPW'(cnt_reg));
                rd_valid_next = rd_en;
                rd_tag_next   = cnt_reg[1:0];
                if (cnt_reg == 3'd1)
                begin
                    cnt_next   = 3'd0;
                    state_next = jos_pkg::S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            jos_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = jos_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = jos_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jos_pkg::S_IDLE;
            sp_reg        <= '0;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rd_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= rd_valid_next;
            rd_tag_reg    <= rd_tag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        dec_reg    <= dec_next;
        status_reg <= status_next;
        if (rd_valid_reg)
            v_reg[rd_tag_reg] <= rd_data_reg;
        if (out_load)
        begin
            out_top_reg    <= (sp_reg != '0) ? v_fwd[0] : 32'd0;
            out_sec_reg    <= (sp_reg > SPW'(1)) ? v_fwd[1] : 32'd0;
            out_depth_reg  <= 7'(sp_reg);
            out_status_reg <= status_reg;
        end
    end

    // Stack RAM
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= stack_mem[rd_addr];
    end

    a_sp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CW'(base_reg) + CW'(cnt_reg) < CW'(STACK_DEPTH)))
        else $error("stack write beyond stack depth");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != jos_pkg::S_IDLE))
        else $error("sequencer stayed idle after a transfer");

    a_error_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && in_status != jos_pkg::STAT_OK)
        |=> (sp_reg == $past(sp_reg)))
        else $error("stack pointer moved on a failed opcode");

endmodule
